[sv/toeq_pkg.sv]
// Shared types and constants for the time-ordered event queue.
`default_nettype none

package toeq_pkg;

  localparam int unsigned QUEUE_DEPTH_DEFAULT = 16;

  localparam int unsigned TIME_W    = 32;
  localparam int unsigned OWNER_W   = 16;
  localparam int unsigned COMMAND_W = 4;
  localparam int unsigned PAYLOAD_W = 32;
  localparam int unsigned OCC_W     = 5;

  localparam int unsigned IN_DATA_W  = 120;
  localparam int unsigned IN_USER_W  = 1;
  localparam int unsigned OUT_DATA_W = 96;
  localparam int unsigned OUT_USER_W = 3;

  localparam logic [COMMAND_W-1:0] HIGHEST_COMMAND_RESET = 4'd15;

  typedef enum logic {
    ACT_INSERT = 1'b0,
    ACT_POLL   = 1'b1
  } action_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_PLACE,
    ST_POLL,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [PAYLOAD_W-1:0] payload;
    logic [COMMAND_W-1:0] command;
    logic [OWNER_W-1:0]   owner;
    logic [TIME_W-1:0]    due_time;
  } entry_t;

endpackage

`default_nettype wire

[sv/time_ordered_event_queue.sv]
// Top level of the time-ordered event queue with its entry memory and sequencer.
`default_nettype none

// Events live in one simple dual-port memory used as a ring, with a head pointer
// and a fill count. A poll reads the head entry and passes it through ST_POLL
// and ST_EMIT to the result word. An insert walks back from the tail, moving
// one later entry up by one slot per cycle through the memory's single write
// port, once for each stored event whose due time is later than the new one.
// A rejected insert and a poll of an empty queue go straight from ST_IDLE to
// ST_EMIT. One word is worked on at a time; a finished result waits in the
// output register while the next word is already taken in.
module time_ordered_event_queue #(
  parameter int unsigned QUEUE_DEPTH = toeq_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 cfg_wr_en,
  input  wire  [toeq_pkg::COMMAND_W-1:0]      cfg_wr_data,
  input  wire                                 s_tvalid,
  output logic                                s_tready,
  // event_time, event_owner, event_command, event_payload, current_time, zero fill
  input  wire  [toeq_pkg::IN_DATA_W-1:0]      s_tdata,
  // action
  input  wire  [toeq_pkg::IN_USER_W-1:0]      s_tuser,
  output logic                                m_tvalid,
  input  wire                                 m_tready,
  // out_owner, out_command, out_payload, out_time, occupancy, zero fill
  output logic [toeq_pkg::OUT_DATA_W-1:0]     m_tdata,
  // removed_valid, command_error, insert_rejected
  output logic [toeq_pkg::OUT_USER_W-1:0]     m_tuser
);
  import toeq_pkg::*;

  localparam int unsigned AW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [AW:0] DEPTH_SUM = (AW + 1)'(QUEUE_DEPTH);
  localparam logic [CW-1:0] DEPTH_CNT = CW'(QUEUE_DEPTH);

  function automatic logic [AW-1:0] wrap(input logic [AW:0] s);
    logic [AW:0] r;
    r = (s >= DEPTH_SUM) ? s - DEPTH_SUM : s;
    return r[AW-1:0];
  endfunction

  entry_t mem [QUEUE_DEPTH];
  entry_t rd_data;

  state_t state, state_next;

  logic [CW-1:0]        count;
  logic [AW-1:0]        head;
  logic [AW-1:0]        idx;
  logic [COMMAND_W-1:0] highest_command;
  entry_t               ins;
  logic [TIME_W-1:0]    now_time;
  entry_t               res_entry;
  logic                 res_removed;
  logic                 res_error;
  logic                 res_rejected;

  logic                 rd_en;
  logic [AW-1:0]        rd_lidx;
  logic                 wr_en;
  logic [AW-1:0]        wr_lidx;
  entry_t               wr_data;

  logic                 accept;
  logic                 is_poll;
  logic                 full;
  logic                 move_up;
  logic                 due;
  logic                 out_free;
  entry_t               in_entry;
  logic [CW+4:0]        count_ext;

  assign s_tready  = (state == ST_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign is_poll   = (action_t'(s_tuser[0]) == ACT_POLL);
  assign full      = (count == DEPTH_CNT);
  assign move_up   = (rd_data.due_time > ins.due_time);
  assign due       = (rd_data.due_time <= now_time);
  assign out_free  = !m_tvalid || m_tready;
  assign count_ext = {5'd0, count};

  assign in_entry.due_time = s_tdata[31:0];
  assign in_entry.owner    = s_tdata[47:32];
  assign in_entry.command  = s_tdata[51:48];
  assign in_entry.payload  = s_tdata[83:52];

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (is_poll) begin
            state_next = (count == '0) ? ST_EMIT : ST_POLL;
          end else if (full) begin
            state_next = ST_EMIT;
          end else begin
            state_next = (count == '0) ? ST_PLACE : ST_WALK;
          end
        end
      end
      ST_WALK: begin
        if (!move_up) begin
          state_next = ST_EMIT;
        end else if (idx == AW'(1)) begin
          state_next = ST_PLACE;
        end
      end
      ST_PLACE: state_next = ST_EMIT;
      ST_POLL:  state_next = ST_EMIT;
      ST_EMIT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    rd_en   = 1'b0;
    rd_lidx = '0;
    wr_en   = 1'b0;
    wr_lidx = idx;
    wr_data = ins;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (is_poll) begin
            rd_en = (count != '0);
          end else begin
            rd_en   = !full && (count != '0);
            rd_lidx = count[AW-1:0] - AW'(1);
          end
        end
      end
      ST_WALK: begin
        wr_en = 1'b1;
        if (move_up) begin
          wr_data = rd_data;
          rd_en   = (idx != AW'(1));
          rd_lidx = idx - AW'(2);
        end
      end
      ST_PLACE: wr_en = 1'b1;
      ST_POLL:  rd_en = 1'b0;
      ST_EMIT:  rd_en = 1'b0;
      default:  rd_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wrap({1'b0, head} + {1'b0, wr_lidx})] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[wrap({1'b0, head} + {1'b0, rd_lidx})];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      count           <= '0;
      head            <= '0;
      m_tvalid        <= 1'b0;
      highest_command <= HIGHEST_COMMAND_RESET;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        highest_command <= cfg_wr_data;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            ins          <= in_entry;
            now_time     <= s_tdata[115:84];
            res_entry    <= '0;
            res_removed  <= 1'b0;
            res_error    <= 1'b0;
            res_rejected <= !is_poll && full;
            idx          <= count[AW-1:0];
          end
        end
        ST_WALK: begin
          if (move_up) begin
            idx <= idx - AW'(1);
          end else begin
            count <= count + CW'(1);
          end
        end
        ST_PLACE: count <= count + CW'(1);
        ST_POLL: begin
          if (due) begin
            res_removed <= 1'b1;
            res_entry   <= rd_data;
            res_error   <= (rd_data.command > highest_command);
            head        <= wrap({1'b0, head} + (AW + 1)'(1));
            count       <= count - CW'(1);
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tuser  <= {res_rejected, res_error, res_removed};
            m_tdata  <= {7'd0, count_ext[4:0], res_entry.due_time, res_entry.payload,
                         res_entry.command, res_entry.owner};
          end
        end
        default: ;
      endcase
      if (m_tvalid && m_tready && !(state == ST_EMIT)) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

[dv/tb_time_ordered_event_queue.sv]
// Testbench for the time-ordered event queue: directed and random traffic checked against a predictor.
`default_nettype none

module tb_time_ordered_event_queue;
  timeunit 1ns;
  timeprecision 1ps;

  import toeq_pkg::*;

  localparam int unsigned DEPTH = QUEUE_DEPTH_DEFAULT;
  localparam int SETTLE_CYCLES = DEPTH + 8;
  localparam int STALL_LIMIT = 4000;

  typedef struct packed {
    logic                 removed;
    logic                 cmd_err;
    logic                 rejected;
    logic [OWNER_W-1:0]   owner;
    logic [COMMAND_W-1:0] command;
    logic [PAYLOAD_W-1:0] payload;
    logic [TIME_W-1:0]    due_time;
    logic [OCC_W-1:0]     occupancy;
  } queue_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_wr_en = 1'b0;
  logic [COMMAND_W-1:0]  cfg_wr_data = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic [IN_USER_W-1:0]  s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [OUT_USER_W-1:0] m_tuser;

  entry_t          sched_events[$];
  logic [3:0]      cmd_limit = HIGHEST_COMMAND_RESET;
  queue_result_t   pending_results[$];
  int              errors = 0;
  int              words_sent = 0;
  int              quiet_cycles = 0;
  int              send_idle_pct = 0;
  int              recv_idle_pct = 0;
  logic [31:0]     tick_base = '0;

  time_ordered_event_queue #(.QUEUE_DEPTH(DEPTH)) DUT (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic queue_result_t predict_queue_step(action_t act, entry_t ev,
                                                       logic [31:0] now);
    queue_result_t r;
    int pos;
    r = '0;
    if (act == ACT_INSERT) begin
      if (sched_events.size() >= DEPTH) begin
        r.rejected = 1'b1;
      end else begin
        pos = 0;
        while (pos < sched_events.size() && sched_events[pos].due_time <= ev.due_time)
          pos++;
        sched_events.insert(pos, ev);
      end
    end else if (sched_events.size() > 0 && sched_events[0].due_time <= now) begin
      r.removed = 1'b1;
      r.owner = sched_events[0].owner;
      r.command = sched_events[0].command;
      r.payload = sched_events[0].payload;
      r.due_time = sched_events[0].due_time;
      r.cmd_err = (sched_events[0].command > cmd_limit);
      void'(sched_events.pop_front());
    end
    r.occupancy = OCC_W'(sched_events.size());
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    queue_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $error("result word with no expectation waiting");
        errors++;
      end else begin
        want = pending_results.pop_front();
        check_field("removed_valid", 32'(want.removed), 32'(m_tuser[0]));
        check_field("command_error", 32'(want.cmd_err), 32'(m_tuser[1]));
        check_field("insert_rejected", 32'(want.rejected), 32'(m_tuser[2]));
        check_field("out_owner", 32'(want.owner), 32'(m_tdata[15:0]));
        check_field("out_command", 32'(want.command), 32'(m_tdata[19:16]));
        check_field("out_payload", want.payload, m_tdata[51:20]);
        check_field("out_time", want.due_time, m_tdata[83:52]);
        check_field("occupancy", 32'(want.occupancy), 32'(m_tdata[88:84]));
        check_field("zero fill", '0, 32'(m_tdata[95:89]));
      end
    end
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || rst)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < STALL_LIMIT) @(posedge clk);
    $display("== FAIL ==");
    $finish;
  end

  task automatic send_word(action_t act, logic [31:0] due, logic [15:0] owner,
                           logic [3:0] command, logic [31:0] payload, logic [31:0] now);
    int gap;
    entry_t ev;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= act;
    s_tdata <= {4'b0, now, payload, command, owner, due};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    ev.due_time = due;
    ev.owner = owner;
    ev.command = command;
    ev.payload = payload;
    pending_results.push_back(predict_queue_step(act, ev, now));
    words_sent++;
    @(negedge clk);
  endtask

  task automatic insert_event(logic [31:0] due, logic [15:0] owner, logic [3:0] command,
                              logic [31:0] payload);
    send_word(ACT_INSERT, due, owner, command, payload, $urandom);
  endtask

  task automatic poll_queue(logic [31:0] now);
    send_word(ACT_POLL, $urandom, 16'($urandom), 4'($urandom), $urandom, now);
  endtask

  // The block is idle only once every result has been taken and the longest
  // insert walk has had time to finish.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_highest_command(logic [3:0] value);
    wait_drained();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    cmd_limit = value;
  endtask

  task automatic test_empty_poll();
    set_highest_command(4'd15);
    poll_queue(32'hFFFF_FFFF);
  endtask

  task automatic test_time_ordering();
    insert_event(32'd100, 16'h0000, 4'd0, 32'h0000_0000);
    insert_event(32'd50, 16'hFFFF, 4'd15, 32'hFFFF_FFFF);
    insert_event(32'd100, 16'h0002, 4'd3, 32'h1234_5678);
    insert_event(32'd0, 16'h5A5A, 4'd9, 32'hA5A5_A5A5);
    insert_event(32'hFFFF_FFFF, 16'hA5A5, 4'd6, 32'h5A5A_5A5A);
    poll_queue(32'd0);
    poll_queue(32'd49);
    poll_queue(32'd100);
    poll_queue(32'd100);
    poll_queue(32'd100);
    poll_queue(32'hFFFF_FFFE);
    poll_queue(32'hFFFF_FFFF);
  endtask

  task automatic test_command_error();
    set_highest_command(4'd0);
    insert_event(32'd5, 16'h0101, 4'd1, 32'h0000_0001);
    insert_event(32'd5, 16'h0202, 4'd0, 32'h0000_0002);
    insert_event(32'd5, 16'h0303, 4'd15, 32'h0000_0003);
    poll_queue(32'd5);
    poll_queue(32'd5);
    poll_queue(32'd5);
  endtask

  task automatic random_fill_burst();
    int extra;
    extra = $urandom_range(1, 3);
    while (sched_events.size() < DEPTH)
      insert_event(tick_base + $urandom_range(0, 24), 16'($urandom), 4'($urandom),
                   $urandom);
    repeat (extra)
      insert_event(tick_base + $urandom_range(0, 24), 16'($urandom), 4'($urandom),
                   $urandom);
  endtask

  task automatic random_mixed_run();
    int len;
    len = $urandom_range(10, 30);
    repeat (len) begin
      if ($urandom_range(99) < 55) begin
        insert_event(tick_base + $urandom_range(0, 24), 16'($urandom), 4'($urandom),
                     $urandom);
      end else begin
        poll_queue(tick_base + $urandom_range(0, 30));
        tick_base += $urandom_range(0, 4);
      end
    end
  endtask

  task automatic random_drain_run();
    int len;
    len = $urandom_range(4, 20);
    repeat (len) begin
      poll_queue(tick_base + $urandom_range(0, 32));
      tick_base += $urandom_range(0, 8);
    end
  endtask

  task automatic random_noise_run();
    int len;
    len = $urandom_range(2, 8);
    repeat (len)
      send_word(action_t'($urandom_range(1)), $urandom, 16'($urandom), 4'($urandom),
                $urandom, $urandom);
  endtask

  task automatic test_random_traffic(int items, int snd_pct, int rcv_pct,
                                     logic [3:0] limit);
    int target;
    int pick;
    set_highest_command(limit);
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    target = words_sent + items;
    tick_base = $urandom_range(1) ? $urandom : 32'hFFFF_FFC0;
    random_fill_burst();
    while (words_sent < target) begin
      pick = $urandom_range(99);
      if (pick < 10)
        random_fill_burst();
      else if (pick < 60)
        random_mixed_run();
      else if (pick < 82)
        random_drain_run();
      else if (pick < 95)
        random_noise_run();
      else
        wait_drained();
    end
  endtask

  initial begin
    rst = 1'b1;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    sched_events.delete();
    cmd_limit = HIGHEST_COMMAND_RESET;
    send_idle_pct = 32;
    recv_idle_pct = 70;
    test_empty_poll();
    test_time_ordering();
    test_command_error();
    test_random_traffic(130, 32, 70, 4'($urandom_range(1, 14)));
    test_random_traffic(130, 70, 32, 4'd15);
    test_random_traffic(130, 0, 0, 4'd0);
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

`default_nettype wire
